// ===== rtl/core/adlw_pkg.sv =====
// ----------------------------------------------------------------------------
// adlw_pkg
// Shared types, constants and helpers for the terminal text line wrapper.
// ----------------------------------------------------------------------------
package adlw_pkg;

    // field and register widths
    localparam int BYTE_W   = 8;
    localparam int VIS_W    = 8;
    localparam int CNT_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam int TDATA_W  = 24;
    localparam int TUSER_W  = 2;

    // register reset values and lower limits
    localparam logic [VIS_W-1:0] LINE_WIDTH_RST     = 8'd80;
    localparam logic [CNT_W-1:0] MAX_LINE_BYTES_RST = 10'd256;
    localparam logic [VIS_W-1:0] MIN_LINE_WIDTH     = 8'd2;
    localparam logic [CNT_W-1:0] MIN_LINE_BYTES     = 10'd4;

    // character codes
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1B;
    localparam logic [BYTE_W-1:0] NL_BYTE    = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] TILDE_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] LEAD_LO    = 8'h81;
    localparam logic [BYTE_W-1:0] LEAD_HI    = 8'hFE;
    localparam logic [BYTE_W-1:0] CSI_BYTE   = 8'h5B;
    localparam logic [BYTE_W-1:0] SEMI_BYTE  = 8'h3B;
    localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH     = 1'b0,
        REG_MAX_LINE_BYTES = 1'b1
    } cfg_reg_t;

    // input word kinds
    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_EOF  = 1'b1
    } kind_t;

    // per-line state
    typedef struct packed {
        logic [VIS_W-1:0] visible_count;
        logic [CNT_W-1:0] consumed_count;
        logic             in_escape;
        logic             in_double_byte;
        logic             break_pending;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '0;

    // one result word
    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] line_bytes;
        logic             line_end;
        logic             byte_valid;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

    // results of one input word: up to two, in order
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    function automatic result_t mk_end(input logic [CNT_W-1:0] lb);
        result_t r;
        r            = '0;
        r.line_end   = 1'b1;
        r.line_bytes = lb;
        return r;
    endfunction

    function automatic result_t mk_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r            = '0;
        r.byte_valid = 1'b1;
        r.out_byte   = b;
        return r;
    endfunction

endpackage

// ===== rtl/core/adlw_step.sv =====
// ----------------------------------------------------------------------------
// adlw_step
// Per-word line state update: escape, double-byte and width/budget breaks.
// ----------------------------------------------------------------------------
module adlw_step (
    input  logic [adlw_pkg::VIS_W-1:0]  line_width,
    input  logic [adlw_pkg::CNT_W-1:0]  max_line_bytes,
    input  adlw_pkg::line_state_t       st,
    input  adlw_pkg::kind_t             kind,
    input  logic [adlw_pkg::BYTE_W-1:0] data_byte,
    output adlw_pkg::line_state_t       st_next,
    output adlw_pkg::step_out_t         res
);

    logic [adlw_pkg::VIS_W-1:0]  w_eff;
    logic [adlw_pkg::VIS_W-1:0]  w_m1;
    logic [adlw_pkg::CNT_W-1:0]  m_eff;
    logic [adlw_pkg::CNT_W-1:0]  m_m1;
    logic [adlw_pkg::CNT_W-1:0]  m_m2;
    logic                        is_esc;
    logic                        is_nl;
    logic                        is_lead;
    logic                        is_code;
    logic                        is_print;
    logic                        bp_cont;
    logic                        bp_nl;
    logic                        bp_end;
    logic                        dbl_cand;
    logic                        lead_end;
    logic                        first_end;
    logic [adlw_pkg::CNT_W-1:0]  end_lb;
    logic [adlw_pkg::CNT_W-1:0]  cc3;
    logic [adlw_pkg::VIS_W-1:0]  vc3;
    logic                        esc3;
    logic [adlw_pkg::BYTE_W-1:0] stored;
    adlw_pkg::line_state_t       s1;
    adlw_pkg::line_state_t       s2;
    adlw_pkg::line_state_t       s3;
    adlw_pkg::result_t           r_main;

    // clamped limits and thresholds
    assign w_eff = (line_width < adlw_pkg::MIN_LINE_WIDTH) ? adlw_pkg::MIN_LINE_WIDTH
                                                           : line_width;
    assign m_eff = (max_line_bytes < adlw_pkg::MIN_LINE_BYTES) ? adlw_pkg::MIN_LINE_BYTES
                                                               : max_line_bytes;
    assign w_m1  = w_eff - 8'd1;
    assign m_m1  = m_eff - 10'd1;
    assign m_m2  = m_eff - 10'd2;

    // character classes
    assign is_esc   = (data_byte == adlw_pkg::ESC_BYTE);
    assign is_nl    = (data_byte == adlw_pkg::NL_BYTE);
    assign is_lead  = data_byte inside {[adlw_pkg::LEAD_LO:adlw_pkg::LEAD_HI]};
    assign is_code  = data_byte inside {adlw_pkg::CSI_BYTE, adlw_pkg::SEMI_BYTE,
                                        [adlw_pkg::DIGIT_LO:adlw_pkg::DIGIT_HI]};
    assign is_print = data_byte[7] ||
                      (data_byte inside {[adlw_pkg::SPACE_BYTE:adlw_pkg::TILDE_BYTE]});

    // held break: escape with room continues, newline swallowed, else breaks
    assign bp_cont = st.break_pending && is_esc && (st.consumed_count < m_m1);
    assign bp_nl   = st.break_pending && is_nl;
    assign bp_end  = st.break_pending && !bp_cont && !bp_nl;

    always_comb begin
        s1 = st;
        s1.break_pending = 1'b0;
        if (bp_end) begin
            s1 = adlw_pkg::LINE_CLEAR;
        end
    end

    // double-byte tracking, lead byte that would not fit breaks first
    assign dbl_cand  = s1.in_double_byte ? 1'b0 : is_lead;
    assign lead_end  = dbl_cand && ((s1.visible_count >= w_m1) || (s1.consumed_count >= m_m2));
    assign first_end = bp_end || lead_end;
    assign end_lb    = bp_end ? st.consumed_count : s1.consumed_count;

    always_comb begin
        s2 = s1;
        if (lead_end) begin
            s2 = adlw_pkg::LINE_CLEAR;
        end
        s2.in_double_byte = dbl_cand;
    end

    // byte intake: escape state, visible count and stored byte
    assign cc3 = s2.consumed_count + 10'd1;

    always_comb begin
        esc3   = s2.in_escape;
        vc3    = s2.visible_count;
        stored = data_byte;
        if (is_esc) begin
            esc3 = 1'b1;
        end else if (s2.in_escape) begin
            esc3 = is_code;
        end else begin
            vc3 = s2.visible_count + 8'd1;
            if (!is_print) begin
                stored = adlw_pkg::SPACE_BYTE;
            end
        end
    end

    always_comb begin
        s3                = s2;
        s3.consumed_count = cc3;
        s3.visible_count  = vc3;
        s3.in_escape      = esc3;
        s3.break_pending  = ((vc3 >= w_eff) || (cc3 >= m_m1)) && !(esc3 && (cc3 < m_m1));
    end

    always_comb begin
        r_main = is_nl ? adlw_pkg::mk_end(cc3) : adlw_pkg::mk_byte(stored);
    end

    // result assembly and next line state
    always_comb begin
        res     = '0;
        st_next = st;
        if (kind == adlw_pkg::KIND_EOF) begin
            st_next = adlw_pkg::LINE_CLEAR;
            res.r0  = adlw_pkg::mk_end(st.consumed_count);
            res.r0.last = 1'b1;
            res.n   = (st.consumed_count != '0) ? 2'd1 : 2'd0;
        end else if (bp_nl) begin
            st_next = adlw_pkg::LINE_CLEAR;
            res.r0  = adlw_pkg::mk_end(st.consumed_count + 10'd1);
            res.r0.last = 1'b1;
            res.n   = 2'd1;
        end else begin
            st_next = is_nl ? adlw_pkg::LINE_CLEAR : s3;
            if (first_end) begin
                res.r0      = adlw_pkg::mk_end(end_lb);
                res.r1      = r_main;
                res.r1.last = 1'b1;
                res.n       = 2'd2;
            end else begin
                res.r0      = r_main;
                res.r0.last = 1'b1;
                res.n       = 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/ansi_dbcs_line_wrapper_core.sv =====
// ----------------------------------------------------------------------------
// ansi_dbcs_line_wrapper_core
// Wraps a terminal text byte stream into display lines of a set width.
// ----------------------------------------------------------------------------
// One input word (a text byte or an end-of-file mark) is taken per clock while
// s_tready is high and its line state update completes in that cycle; its one or
// two result words go into a four-word registered output queue. Input is accepted
// while the queue holds at most two words, so a stream of single-result bytes
// flows at one word per cycle while m_tready is high, with no dependence between
// s_tready and m_tready. A word that causes two results (a line break followed by
// the byte) needs an output handshake for each, which limits the long-run rate on
// such streams. No clearing pass after reset; configuration is to be written
// through cfg_wr_en only while idle, which the block does not enforce.
module ansi_dbcs_line_wrapper_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [adlw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adlw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adlw_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] kind
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adlw_pkg::TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [17:8] line_bytes
    output logic [adlw_pkg::TUSER_W-1:0]      m_tuser,   // [0] byte_valid, [1] line_end
    output logic                              m_tlast
);

    logic [adlw_pkg::VIS_W-1:0] line_width_reg;
    logic [adlw_pkg::CNT_W-1:0] max_line_bytes_reg;
    adlw_pkg::line_state_t      line_reg;
    adlw_pkg::line_state_t      line_next;
    adlw_pkg::step_out_t        step_res;
    adlw_pkg::result_t          q_reg [4];
    logic [1:0]                 wr_ptr_reg;
    logic [1:0]                 rd_ptr_reg;
    logic [2:0]                 cnt_reg;
    logic [2:0]                 cnt_next;
    logic                       s_acc;
    logic                       m_acc;
    logic [1:0]                 push_n;
    adlw_pkg::result_t          head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg     <= adlw_pkg::LINE_WIDTH_RST;
            max_line_bytes_reg <= adlw_pkg::MAX_LINE_BYTES_RST;
        end else if (cfg_wr_en) begin
            case (adlw_pkg::cfg_reg_t'(cfg_index))
                adlw_pkg::REG_LINE_WIDTH:     line_width_reg     <= cfg_wdata[adlw_pkg::VIS_W-1:0];
                adlw_pkg::REG_MAX_LINE_BYTES: max_line_bytes_reg <= cfg_wdata[adlw_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign s_tready = (cnt_reg <= 3'd2);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    // line state update
    adlw_step u_step (
        .line_width     (line_width_reg),
        .max_line_bytes (max_line_bytes_reg),
        .st             (line_reg),
        .kind           (adlw_pkg::kind_t'(s_tuser)),
        .data_byte      (s_tdata),
        .st_next        (line_next),
        .res            (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= adlw_pkg::LINE_CLEAR;
        end else if (s_acc) begin
            line_reg <= line_next;
        end
    end

    // output queue
    assign push_n   = s_acc ? step_res.n : 2'd0;
    assign cnt_next = cnt_reg + {1'b0, push_n} - {2'b00, m_acc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, m_acc};
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= step_res.r0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= step_res.r1;
        end
    end

    // result word
    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {6'd0, head.line_bytes, head.out_byte};
    assign m_tuser  = {head.line_end, head.byte_valid};
    assign m_tlast  = head.last;

endmodule

// ===== rtl/core/adlw_checker.sv =====
// ----------------------------------------------------------------------------
// adlw_checker
// Port-level checks for the line wrapper, bound to the top level.
// ----------------------------------------------------------------------------
module adlw_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready
);

    // queue is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word shown after reset");

    // input only stalls while results are waiting
    a_stall_backed: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // every data byte gives at least one result
    a_byte_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser) |=> m_tvalid)
        else $error("data byte gave no result");

    // a stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result word withdrawn under stall");

endmodule

bind ansi_dbcs_line_wrapper_core adlw_checker u_adlw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
